[design/fms_pkg.sv]
// ----------------------------------------------------------------------------
// fms_pkg
// Shared types and constants for the frame motion statistics block.
// ----------------------------------------------------------------------------
package fms_pkg;

  // Field and accumulator widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned FW_W     = 13;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned SUM_W    = 37;
  localparam int unsigned SQ_W     = 49;
  localparam int unsigned Q8_W     = 20;
  localparam int unsigned PROD_W   = 74;
  localparam int unsigned MPL_W    = 37;
  localparam int unsigned DVD_W    = 90;
  localparam int unsigned DVS_W    = 50;
  localparam int unsigned QUO_W    = 48;
  localparam int unsigned ITER_W   = 7;
  localparam int unsigned STEP_W   = 4;

  // Deviation limit 100.0 in Q.16 variance units: 100^2 * 65536
  localparam logic [QUO_W-1:0] VAR_LIMIT = QUO_W'(655360000);

  // Frame-end compute sequence
  localparam logic [STEP_W-1:0] STEP_NN  = 4'd0;  // n*n
  localparam logic [STEP_W-1:0] STEP_CX  = 4'd1;  // 256*sx/n
  localparam logic [STEP_W-1:0] STEP_CY  = 4'd2;  // 256*sy/n
  localparam logic [STEP_W-1:0] STEP_PX  = 4'd3;  // n*sqx
  localparam logic [STEP_W-1:0] STEP_SSX = 4'd4;  // sx*sx, then difference
  localparam logic [STEP_W-1:0] STEP_DX  = 4'd5;  // 65536*D/nn
  localparam logic [STEP_W-1:0] STEP_RX  = 4'd6;  // isqrt
  localparam logic [STEP_W-1:0] STEP_PY  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SSY = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DY  = 4'd9;
  localparam logic [STEP_W-1:0] STEP_RY  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_RY;

  // Controller to datapath
  typedef struct packed {
    logic                   pix_en;  // pixel beat accepted
    logic                   clr;     // clear frame accumulators
    logic                   start;   // launch one compute step
    logic [STEP_W-1:0]      step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic done;  // compute step finished
  } sts_t;

endpackage

[design/frame_motion_statistics_top.sv]
// ----------------------------------------------------------------------------
// frame_motion_statistics_top
// Thresholded motion statistics over a difference-image pixel stream.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_axis    in   tdata: pixel[7:0]; tlast: last_pixel
//  m_axis    out  tdata: motion, changed_count, mean_x/y, spread_x/y
//  apb       in   0x0 pixel_threshold, 0x4 count_threshold, 0x8 frame_width
//
//  Pixels are taken one per cycle while a frame is accumulating.
//  After the last beat the shared serial units run 11 steps in turn
//  (multiplies, divides and roots, each loading its operands, iterating and
//  committing its result); the result beat is valid when the last step ends.
//  No pixel is taken then, nor while the result beat waits on m_axis_tready.
//  Reset clears counters and sums; frame_width resets to 640.
// ----------------------------------------------------------------------------
module frame_motion_statistics_top #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] pixel
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] motion, [25:1] changed_count, [45:26] mean_x_q8,
  // [65:46] mean_y_q8, [85:66] spread_x_q8, [105:86] spread_y_q8
  output logic [111:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic [1:0] REG_PIX_THR = 2'd0;
  localparam logic [1:0] REG_CNT_THR = 2'd1;
  localparam logic [1:0] REG_FWIDTH  = 2'd2;

  logic [fms_pkg::PIX_W-1:0] pix_thr_q;
  logic [fms_pkg::CNT_W-1:0] cnt_thr_q;
  logic [fms_pkg::FW_W-1:0]  fw_q;
  logic                      wr_en;

  // Register file
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_thr_q <= '0;
      cnt_thr_q <= '0;
      fw_q      <= fms_pkg::FW_W'(640);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_PIX_THR: pix_thr_q <= pwdata[fms_pkg::PIX_W-1:0];
        REG_CNT_THR: cnt_thr_q <= pwdata[fms_pkg::CNT_W-1:0];
        REG_FWIDTH:  fw_q      <= pwdata[fms_pkg::FW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PIX_THR: prdata = 32'(pix_thr_q);
      REG_CNT_THR: prdata = 32'(cnt_thr_q);
      REG_FWIDTH:  prdata = 32'(fw_q);
      default:     prdata = '0;
    endcase
  end

  fms_pkg::cmd_t cmd;
  fms_pkg::sts_t sts;
  logic                      motion;
  logic [fms_pkg::CNT_W-1:0] cnt;
  logic [fms_pkg::Q8_W-1:0]  cx, cy, spx, spy;

  fms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fms_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .pixel_i         (s_axis_tdata),
    .pix_thr_i       (pix_thr_q),
    .cnt_thr_i       (cnt_thr_q),
    .frame_width_i   (fw_q),
    .motion_o        (motion),
    .changed_count_o (cnt),
    .mean_x_o        (cx),
    .mean_y_o        (cy),
    .spread_x_o      (spx),
    .spread_y_o      (spy)
  );

  assign m_axis_tdata = {6'd0, spy, spx, cy, cx, cnt, motion};

endmodule

[design/fms_ctrl.sv]
// ----------------------------------------------------------------------------
// fms_ctrl
// Sequencer: pixel intake, frame-end compute steps and result handoff.
// ----------------------------------------------------------------------------
module fms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output fms_pkg::cmd_t   cmd_o,
  input  fms_pkg::sts_t   sts_i
);

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [fms_pkg::STEP_W-1:0]   step_q, step_d;
  logic                         start_q, start_d;
  logic                         pix_beat;

  assign in_ready_o  = (state_q == ST_ACC);
  assign out_valid_o = (state_q == ST_OUT);
  assign pix_beat    = in_valid_i & in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    start_d = 1'b0;
    unique case (state_q)
      ST_ACC: begin
        if (pix_beat && in_last_i) begin
          state_d = ST_CALC;
          step_d  = fms_pkg::STEP_NN;
          start_d = 1'b1;
        end
      end
      ST_CALC: begin
        if (sts_i.done) begin
          if (step_q == fms_pkg::STEP_LAST) begin
            state_d = ST_OUT;
          end else begin
            step_d  = step_q + 1'b1;
            start_d = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_ACC;
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      step_q  <= fms_pkg::STEP_NN;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      start_q <= start_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o.pix_en = pix_beat;
    cmd_o.clr    = (state_q == ST_OUT) & out_ready_i;
    cmd_o.start  = start_q;
    cmd_o.step   = step_q;
  end

endmodule

[design/fms_dp.sv]
// ----------------------------------------------------------------------------
// fms_dp
// Datapath: position tracking, accumulators, and a shared serial
// multiplier, restoring divider and integer square root.
// ----------------------------------------------------------------------------
module fms_dp #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fms_pkg::cmd_t                cmd_i,
  output fms_pkg::sts_t                sts_o,
  input  logic [fms_pkg::PIX_W-1:0]    pixel_i,
  input  logic [fms_pkg::PIX_W-1:0]    pix_thr_i,
  input  logic [fms_pkg::CNT_W-1:0]    cnt_thr_i,
  input  logic [fms_pkg::FW_W-1:0]     frame_width_i,
  output logic                         motion_o,
  output logic [fms_pkg::CNT_W-1:0]    changed_count_o,
  output logic [fms_pkg::Q8_W-1:0]     mean_x_o,
  output logic [fms_pkg::Q8_W-1:0]     mean_y_o,
  output logic [fms_pkg::Q8_W-1:0]     spread_x_o,
  output logic [fms_pkg::Q8_W-1:0]     spread_y_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW = fms_pkg::PROD_W;
  localparam int unsigned MW = fms_pkg::MPL_W;
  localparam int unsigned DW = fms_pkg::DVD_W;
  localparam int unsigned VW = fms_pkg::DVS_W;
  localparam int unsigned QW = fms_pkg::QUO_W;
  localparam int unsigned IW = fms_pkg::ITER_W;
  localparam int unsigned SQRT_STEPS = QW / 2;

  // ---------------- position and accumulation ----------------
  logic [CW-1:0]                 col_q;
  logic [RW-1:0]                 row_q;
  logic [fms_pkg::CNT_W-1:0]     hit_q;
  logic [fms_pkg::SUM_W-1:0]     sx_q, sy_q;
  logic [fms_pkg::SQ_W-1:0]      sqx_q, sqy_q;
  logic [fms_pkg::FW_W:0]        eff_w;
  logic [fms_pkg::FW_W:0]        col_p1;
  logic                          hit;
  logic [fms_pkg::COORD_W-1:0]   x_c, y_c;

  // Clamp the row width into 1..MAX_WIDTH
  always_comb begin
    if (frame_width_i == '0) begin
      eff_w = (fms_pkg::FW_W+1)'(1);
    end else if ((fms_pkg::FW_W+1)'(frame_width_i) > (fms_pkg::FW_W+1)'(MAX_WIDTH)) begin
      eff_w = (fms_pkg::FW_W+1)'(MAX_WIDTH);
    end else begin
      eff_w = (fms_pkg::FW_W+1)'(frame_width_i);
    end
  end

  assign col_p1 = (fms_pkg::FW_W+1)'(col_q) + 1'b1;
  assign hit    = (pixel_i > pix_thr_i) && (hit_q != '1);
  assign x_c    = fms_pkg::COORD_W'(col_q);
  assign y_c    = fms_pkg::COORD_W'(row_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      hit_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sqx_q <= '0;
      sqy_q <= '0;
    end else if (cmd_i.clr) begin
      col_q <= '0;
      row_q <= '0;
      hit_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sqx_q <= '0;
      sqy_q <= '0;
    end else if (cmd_i.pix_en) begin
      if (hit) begin
        hit_q <= hit_q + 1'b1;
        sx_q  <= sx_q + fms_pkg::SUM_W'(x_c);
        sy_q  <= sy_q + fms_pkg::SUM_W'(y_c);
        sqx_q <= sqx_q + fms_pkg::SQ_W'(x_c) * fms_pkg::SQ_W'(x_c);
        sqy_q <= sqy_q + fms_pkg::SQ_W'(y_c) * fms_pkg::SQ_W'(y_c);
      end
      if (col_p1 >= eff_w) begin
        col_q <= '0;
        if (row_q < RW'(MAX_HEIGHT - 1)) row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // ---------------- shared arithmetic units ----------------
  logic [fms_pkg::STEP_W-1:0] step_q;
  logic                       busy_q;
  logic [IW-1:0]              iter_q;
  // multiplier
  logic [PW-1:0]              mcand_q, prod_q;
  logic [MW-1:0]              mplier_q;
  // divider
  logic [DW-1:0]              dvd_q;
  logic [VW-1:0]              dvs_q, rem_q;
  logic [QW-1:0]              quo_q;
  logic [VW:0]                trial;
  // square root
  logic [QW-1:0]              sv_q, sres_q, sbit_q, sarg;
  // step results
  logic [VW-1:0]              nn_q;
  logic [PW-1:0]              p1_q;
  logic [PW-1:0]              d_q;
  logic [QW-1:0]              q_q;
  logic [fms_pkg::Q8_W-1:0]   cx_q, cy_q, spx_q, spy_q;
  logic                       wx_q, wy_q;
  logic                       wide;
  logic [PW-1:0]              diff;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign sarg  = sres_q + sbit_q;
  assign wide  = (quo_q > fms_pkg::VAR_LIMIT) ||
                 ((quo_q == fms_pkg::VAR_LIMIT) && (rem_q != '0));
  assign diff  = (prod_q > p1_q) ? '0 : (p1_q - prod_q);

  // Step control and operand load
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      iter_q <= '0;
      step_q <= fms_pkg::STEP_NN;
    end else if (cmd_i.start) begin
      busy_q <= 1'b1;
      step_q <= cmd_i.step;
      unique case (cmd_i.step)
        fms_pkg::STEP_CX, fms_pkg::STEP_CY,
        fms_pkg::STEP_DX, fms_pkg::STEP_DY: iter_q <= IW'(DW);
        fms_pkg::STEP_RX, fms_pkg::STEP_RY: iter_q <= IW'(SQRT_STEPS);
        default:                            iter_q <= IW'(MW);
      endcase
    end else if (busy_q) begin
      if (iter_q != '0) iter_q <= iter_q - 1'b1;
      else              busy_q <= 1'b0;
    end
  end

  assign sts_o.done = busy_q && (iter_q == '0);

  // Unit registers: load on start, iterate while counting
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      prod_q <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      sres_q <= '0;
      sbit_q <= QW'(1) << (QW - 2);
      unique case (cmd_i.step)
        fms_pkg::STEP_NN: begin
          mcand_q  <= PW'(hit_q);
          mplier_q <= MW'(hit_q);
        end
        fms_pkg::STEP_PX: begin
          mcand_q  <= PW'(sqx_q);
          mplier_q <= MW'(hit_q);
        end
        fms_pkg::STEP_PY: begin
          mcand_q  <= PW'(sqy_q);
          mplier_q <= MW'(hit_q);
        end
        fms_pkg::STEP_SSX: begin
          mcand_q  <= PW'(sx_q);
          mplier_q <= MW'(sx_q);
        end
        fms_pkg::STEP_SSY: begin
          mcand_q  <= PW'(sy_q);
          mplier_q <= MW'(sy_q);
        end
        fms_pkg::STEP_CX: begin
          dvd_q <= DW'({sx_q, 8'd0});
          dvs_q <= VW'(hit_q);
        end
        fms_pkg::STEP_CY: begin
          dvd_q <= DW'({sy_q, 8'd0});
          dvs_q <= VW'(hit_q);
        end
        fms_pkg::STEP_DX, fms_pkg::STEP_DY: begin
          dvd_q <= DW'({d_q, 16'd0});
          dvs_q <= nn_q;
        end
        fms_pkg::STEP_RX, fms_pkg::STEP_RY: begin
          sv_q <= q_q;
        end
        default: ;
      endcase
    end else if (busy_q && (iter_q != '0)) begin
      // one multiply bit
      if (mplier_q[0]) prod_q <= prod_q + mcand_q;
      mcand_q  <= mcand_q << 1;
      mplier_q <= mplier_q >> 1;
      // one quotient bit
      if (trial >= (VW+1)'(dvs_q)) begin
        rem_q <= VW'(trial - (VW+1)'(dvs_q));
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= VW'(trial);
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
      dvd_q <= dvd_q << 1;
      // one root bit
      if (sv_q >= sarg) begin
        sv_q   <= sv_q - sarg;
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  // Commit step results
  always_ff @(posedge clk_i) begin
    if (sts_o.done) begin
      case (step_q)
        fms_pkg::STEP_NN:  nn_q  <= VW'(prod_q);
        fms_pkg::STEP_CX:  cx_q  <= quo_q[fms_pkg::Q8_W-1:0];
        fms_pkg::STEP_CY:  cy_q  <= quo_q[fms_pkg::Q8_W-1:0];
        fms_pkg::STEP_PX, fms_pkg::STEP_PY: p1_q <= prod_q;
        fms_pkg::STEP_SSX, fms_pkg::STEP_SSY: d_q <= diff;
        fms_pkg::STEP_DX: begin
          q_q  <= quo_q;
          wx_q <= wide;
        end
        fms_pkg::STEP_DY: begin
          q_q  <= quo_q;
          wy_q <= wide;
        end
        fms_pkg::STEP_RX:  spx_q <= sres_q[fms_pkg::Q8_W-1:0];
        fms_pkg::STEP_RY:  spy_q <= sres_q[fms_pkg::Q8_W-1:0];
        default: ;
      endcase
    end
  end

  // Result fields; an empty frame reads as all zero
  logic nz;
  assign nz              = (hit_q != '0);
  assign changed_count_o = hit_q;
  assign mean_x_o        = nz ? cx_q  : '0;
  assign mean_y_o        = nz ? cy_q  : '0;
  assign spread_x_o      = nz ? spx_q : '0;
  assign spread_y_o      = nz ? spy_q : '0;
  assign motion_o        = nz && (hit_q > cnt_thr_i) && !wx_q && !wy_q;

endmodule
